// ===== design/pwl_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the piecewise linear table interpolator
package pwl_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_DECREASING = 2'd2,
    STATUS_RANGE      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_RDZ,
    S_WAITZ,
    S_RDA,
    S_RDB,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_DIV,
    S_DONE
  } state_e;

endpackage

// ===== design/piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps
// piecewise linear table interpolator top level
//
// Holds 64 breakpoints (key, value) in signed Q16.16 in two synchronous
// memories with one write and one read port each and answers one transaction
// at a time. A load transaction writes one slot and is acknowledged with
// status ok in the following cycle. A query first streams the active entries
// (entry_count, capped at 64) through the key memory read port, one entry per
// cycle, checking that keys never decrease, capturing the first and last keys
// and the segment around the query. It then reads the two segment values,
// forms the weighted sum with one shared 33x32 multiplier and divides it by
// the key gap with a restoring divider that retires one quotient bit per
// cycle, truncating toward zero. A query runs through the key scan, the
// segment reads, the multiplies, the add and the 64-step divider before its
// result is registered; error results and queries that hit the first key
// exactly return right after the scan. An empty table skips the scan and
// answers directly from S_DONE. A result waits in an output register while
// downstream stalls; the next transaction is taken once the block is idle
// and the result register is free or being drained. entry_count is written
// through its own port, which is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
module piecewise_linear_table_interp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pwl_pkg::CountW-1:0]  cfg_data_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [pwl_pkg::AddrW-1:0]   slot_i,
  input  logic signed [31:0]          entry_key_i,
  input  logic signed [31:0]          entry_value_i,
  input  logic signed [31:0]          query_pos_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          interp_value_o,
  output logic [1:0]                  status_o
);
  import pwl_pkg::*;

  // table storage, one read port each, registered read data
  logic [31:0] key_mem [TableDepth];
  logic [31:0] val_mem [TableDepth];
  logic [31:0] key_rd_q;
  logic [31:0] val_rd_q;
  logic [AddrW-1:0] rd_addr;

  // control
  state_e state_q, state_d;
  logic [CountW-1:0] entry_count_q;
  logic [CountW-1:0] n_q;
  logic [CountW-1:0] scan_q;
  logic [CountW-1:0] chk_idx_q;
  logic              chk_vld_q;
  logic              found_q;
  logic              dec_q;
  logic [AddrW-1:0]  seg_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic              out_vld_q;

  // datapath
  logic signed [31:0] q_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] key0_q;
  logic signed [31:0] keyl_q;
  logic signed [31:0] k0_q;
  logic signed [31:0] k1_q;
  logic signed [31:0] v0_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic [63:0]        div_q;
  logic [32:0]        rem_q;
  logic [31:0]        gap_q;
  logic               neg_q;
  logic signed [31:0] res_q;
  logic [1:0]         res_st_q;
  logic signed [31:0] out_val_q;
  logic [1:0]         out_st_q;

  logic in_acc, out_free, issue, last_chk, do_load, do_query;
  logic [CountW-1:0] n_cap;
  logic signed [31:0] k_cur;
  logic [32:0] bwd_w, fwd_w, gap_w;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [63:0] num_w;
  logic [32:0] rem_sh;
  logic [33:0] rem_sub;

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_vld_q;
  assign interp_value_o = out_val_q;
  assign status_o       = out_st_q;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign do_load    = in_acc && (func_i == FuncLoad);
  assign do_query   = in_acc && (func_i == FuncQuery);

  // entry_count saturates at the table depth
  assign n_cap = (entry_count_q > CountW'(TableDepth)) ? CountW'(TableDepth) : entry_count_q;

  assign issue    = (state_q == S_SCAN) && (scan_q < n_q);
  assign last_chk = chk_vld_q && (chk_idx_q == n_q - CountW'(1));
  assign k_cur    = $signed(key_rd_q);

  // segment arithmetic, all differences are non-negative inside the range
  assign bwd_w = {q_q[31], q_q} - {k0_q[31], k0_q};
  assign fwd_w = {k1_q[31], k1_q} - {q_q[31], q_q};
  assign gap_w = {k1_q[31], k1_q} - {k0_q[31], k0_q};
  assign mul_a = (state_q == S_MUL1) ? $signed({1'b0, bwd_w[31:0]})
                                     : $signed({1'b0, fwd_w[31:0]});
  assign mul_b = (state_q == S_MUL1) ? $signed(val_rd_q) : v0_q;
  assign mul_p = mul_a * mul_b;
  assign num_w = acc_q + prod_q;

  // restoring divide step
  assign rem_sh  = {rem_q[31:0], div_q[63]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, gap_q};

  always_comb begin
    case (state_q)
      S_SCAN:  rd_addr = scan_q[AddrW-1:0];
      S_RDA:   rd_addr = seg_q - AddrW'(1);
      S_RDB:   rd_addr = seg_q;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      key_mem[slot_i] <= entry_key_i;
      val_mem[slot_i] <= entry_value_i;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (do_query) begin
          state_d = (n_cap == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_chk) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (dec_q || (q_q < key0_q) || (q_q > keyl_q)) state_d = S_DONE;
        else if (q_q == key0_q)                         state_d = S_RDZ;
        else                                            state_d = S_RDA;
      end
      S_RDZ:   state_d = S_WAITZ;
      S_WAITZ: state_d = S_DONE;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_ADD;
      S_ADD:   state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DivCntW'(DivSteps - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_count_q <= '0;
      n_q           <= '0;
      scan_q        <= '0;
      chk_idx_q     <= '0;
      chk_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      dec_q         <= 1'b0;
      seg_q         <= '0;
      div_cnt_q     <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) entry_count_q <= cfg_data_i;

      if (do_query) begin
        n_q       <= n_cap;
        scan_q    <= '0;
        chk_vld_q <= 1'b0;
        found_q   <= 1'b0;
        dec_q     <= 1'b0;
      end

      if (state_q == S_SCAN) begin
        chk_vld_q <= issue;
        chk_idx_q <= scan_q;
        if (issue) scan_q <= scan_q + CountW'(1);
      end

      // per-entry checks on the key coming out of memory
      if (chk_vld_q) begin
        if ((chk_idx_q != '0) && (k_cur < prev_q)) dec_q <= 1'b1;
        if (!found_q && (chk_idx_q != '0) && ((k_cur >= q_q) || last_chk)) begin
          found_q <= 1'b1;
          seg_q   <= chk_idx_q[AddrW-1:0];
        end
      end

      if (state_q == S_ADD) div_cnt_q <= '0;
      else if (state_q == S_DIV) div_cnt_q <= div_cnt_q + DivCntW'(1);

      // result register: a load answers at once, a query from S_DONE
      if (do_load) begin
        out_vld_q <= 1'b1;
      end else if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      out_val_q <= '0;
      out_st_q  <= STATUS_OK;
    end else if ((state_q == S_DONE) && out_free) begin
      out_val_q <= res_q;
      out_st_q  <= res_st_q;
    end

    if (do_query) begin
      q_q      <= query_pos_i;
      res_q    <= '0;
      res_st_q <= STATUS_EMPTY;
    end

    if (chk_vld_q) begin
      prev_q <= k_cur;
      if (chk_idx_q == '0) key0_q <= k_cur;
      if (last_chk)        keyl_q <= k_cur;
      if (!found_q && (chk_idx_q != '0) && ((k_cur >= q_q) || last_chk)) begin
        k0_q <= prev_q;
        k1_q <= k_cur;
      end
    end

    case (state_q)
      S_CHECK: begin
        res_q <= '0;
        if (dec_q)                                res_st_q <= STATUS_DECREASING;
        else if ((q_q < key0_q) || (q_q > keyl_q)) res_st_q <= STATUS_RANGE;
        else                                      res_st_q <= STATUS_OK;
        gap_q <= gap_w[31:0];
      end
      S_WAITZ: res_q <= $signed(val_rd_q);
      S_RDB:   v0_q  <= $signed(val_rd_q);
      S_MUL1:  prod_q <= mul_p[63:0];
      S_MUL2: begin
        acc_q  <= prod_q;
        prod_q <= mul_p[63:0];
      end
      S_ADD: begin
        neg_q <= num_w[63];
        div_q <= num_w[63] ? 64'(-num_w) : 64'(num_w);
        rem_q <= '0;
      end
      S_DIV: begin
        if (!rem_sub[33]) begin
          rem_q <= rem_sub[32:0];
          div_q <= {div_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          div_q <= {div_q[62:0], 1'b0};
        end
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          // last quotient bit lands here, fold in the sign
          if (neg_q) begin
            res_q <= -$signed({div_q[30:0], !rem_sub[33]});
          end else begin
            res_q <= $signed({div_q[30:0], !rem_sub[33]});
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/pwl_interp_checker.sv =====
`timescale 1ns / 1ps
// result checker for the piecewise linear table interpolator
module pwl_interp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               func_i,
  input  logic [5:0]         slot_i,
  input  logic signed [31:0] entry_key_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] query_pos_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] interp_value_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import pwl_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
  } interp_result_t;

  logic signed [31:0] keys [TableDepth];
  logic signed [31:0] vals [TableDepth];
  int unsigned        active_entries;
  // expected results in order, ring of 16 with free-running pointers
  interp_result_t     expected_results [16];
  int unsigned        exp_wr_ptr;
  int unsigned        exp_rd_ptr;

  assign pending_o = int'(exp_wr_ptr - exp_rd_ptr);

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // bit-exact interpolation of one query against the current table
  function automatic interp_result_t interpolate(input logic signed [31:0] q);
    interp_result_t r;
    int unsigned n, i;
    longint gap, fwd, bwd, num;
    r.value = '0;
    r.status = STATUS_OK;
    n = (active_entries > TableDepth) ? TableDepth : active_entries;
    if (n == 0) begin
      r.status = STATUS_EMPTY;
      return r;
    end
    for (i = 0; i + 1 < n; i++) begin
      if (keys[i+1] < keys[i]) begin
        r.status = STATUS_DECREASING;
        return r;
      end
    end
    if (q < keys[0] || q > keys[n-1]) begin
      r.status = STATUS_RANGE;
      return r;
    end
    if (q == keys[0]) begin
      r.value = vals[0];
      return r;
    end
    i = 1;
    while (i < n - 1 && keys[i] < q) i++;
    gap = longint'(keys[i]) - longint'(keys[i-1]);
    fwd = longint'(keys[i]) - longint'(q);
    bwd = longint'(q) - longint'(keys[i-1]);
    num = bwd * longint'(vals[i]) + fwd * longint'(vals[i-1]);
    r.value = 32'(num / gap);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    interp_result_t want;
    if (!rst_ni) begin
      active_entries = 0;
      fail_count_o = 0;
      exp_wr_ptr = 0;
      exp_rd_ptr = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) active_entries = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FuncLoad) begin
          keys[slot_i] = entry_key_i;
          vals[slot_i] = entry_value_i;
          want.value = '0;
          want.status = STATUS_OK;
        end else begin
          want = interpolate(query_pos_i);
        end
        expected_results[exp_wr_ptr[3:0]] = want;
        exp_wr_ptr++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (exp_wr_ptr == exp_rd_ptr) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_results[exp_rd_ptr[3:0]];
          exp_rd_ptr++;
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
          if (interp_value_i !== want.value)
            report_mismatch($sformatf("value %h, expected %h", interp_value_i, want.value));
        end
      end
    end
  end
endmodule

// ===== tb/tb_piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the piecewise linear table interpolator
module tb_piecewise_linear_table_interp;
  import pwl_pkg::*;

  localparam int CycleLimit = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [6:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               func_i = FuncLoad;
  logic [5:0]         slot_i = '0;
  logic signed [31:0] entry_key_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic signed [31:0] query_pos_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] interp_value_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending;

  // idle odds in percent for each side, and a long hold-off request
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_armed = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  // key mirror so queries land near the loaded breakpoints
  logic signed [31:0] shadow_keys [64];
  int unsigned        active_n = 0;

  always #2 clk_i = ~clk_i;

  piecewise_linear_table_interp dut (.*);

  pwl_interp_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .slot_i, .entry_key_i,
    .entry_value_i, .query_pos_i, .out_valid_i(out_valid_o), .out_stall_i,
    .interp_value_i(interp_value_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_req && !hold_armed) begin
      hold_armed  <= 1'b1;
      hold_cycles <= 2000;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one input transaction, valid stays up until the next call or idle_input
  task automatic send_item(input logic f, input logic [5:0] s, input logic signed [31:0] k,
                           input logic signed [31:0] v, input logic signed [31:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    slot_i <= s;
    entry_key_i <= k;
    entry_value_i <= v;
    query_pos_i <= q;
    if (f == FuncLoad) begin
      shadow_keys[s] = k;
    end
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain everything, settle, then write entry_count
  task automatic set_count(input int unsigned n);
    idle_input();
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= 7'(n);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_n = (n > 64) ? 64 : n;
  endtask

  function automatic logic signed [31:0] rand32();
    return $urandom();
  endfunction

  // query safe for the current table: any position, slots below count loaded
  function automatic logic signed [31:0] pick_query();
    int unsigned sel;
    longint span;
    sel = $urandom_range(9);
    if (active_n == 0 || sel < 2) return rand32();
    if (sel < 5) return shadow_keys[$urandom_range(active_n - 1)];
    if (sel < 6) return shadow_keys[$urandom_range(active_n - 1)] + $signed($urandom_range(2)) - 1;
    span = longint'(shadow_keys[active_n-1]) - longint'(shadow_keys[0]) + 1;
    if (span <= 0) return rand32();
    return shadow_keys[0] + 32'(longint'($urandom()) % span);
  endfunction

  // load a sorted table of n entries with random keys and values
  task automatic load_sorted(input int unsigned n, input bit wide);
    logic signed [31:0] k;
    int unsigned i;
    k = wide ? 32'sh8000_0000 + $urandom_range(1000) : $signed($urandom_range(4000)) - 2000;
    for (i = 0; i < n; i++) begin
      send_item(FuncLoad, 6'(i), k, rand32(), rand32());
      if (wide) k = k + $signed($urandom_range(32'h7FFF_FFFF / n));
      else k = k + $signed($urandom_range(3) == 0 ? 0 : $urandom_range(70000));
    end
  endtask

  task automatic query_all(input int unsigned count);
    repeat (count) send_item(FuncQuery, 6'($urandom()), rand32(), rand32(), pick_query());
  endtask

  int unsigned phase, n;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, first-key hit, extremes, decreasing keys
    send_item(FuncQuery, '0, '0, '0, 32'sh7FFF_FFFF);
    send_item(FuncLoad, 6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
    send_item(FuncLoad, 6'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
    send_item(FuncLoad, 6'd63, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    set_count(1);
    send_item(FuncQuery, '0, '0, '0, 32'sh8000_0000);
    send_item(FuncQuery, '0, '0, '0, 32'sh7FFF_FFFF);
    set_count(2);
    send_item(FuncQuery, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_item(FuncQuery, '0, '0, '0, 32'sh7FFF_FFFF);
    send_item(FuncQuery, '0, '0, '0, 0);
    send_item(FuncQuery, '0, '0, '0, -1);
    send_item(FuncLoad, 6'd1, 32'sh8000_0000, 32'sh1234_5678, '0);
    send_item(FuncQuery, '0, '0, '0, 32'sh8000_0000);
    send_item(FuncLoad, 6'd1, -32'sh1, 5, '0);
    send_item(FuncQuery, '0, '0, '0, -32'sh1000);
    send_item(FuncLoad, 6'd2, 32'sh8000_0000, 5, '0);
    set_count(3);
    send_item(FuncQuery, '0, '0, '0, 0);
    set_count(0);
    send_item(FuncQuery, '0, '0, '0, 0);

    // random phases with different idling and table sizes
    for (phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      n = (phase == 5) ? 64 : (phase == 11 ? 127 : $urandom_range(1, 12));
      set_count(0);
      load_sorted(n > 64 ? 64 : n, phase % 3 == 0);
      // an occasional random key in an active slot, which may put keys out of order
      if ($urandom_range(3) == 0)
        send_item(FuncLoad, 6'($urandom_range((n > 64 ? 64 : n) - 1)), rand32(), rand32(), rand32());
      set_count(n);
      if (phase == 3) hold_req = 1'b1;
      query_all(phase == 5 || phase == 11 ? 40 : 70);
      // loads mixed with queries, into unused slots unless the table is full
      repeat (10) begin
        send_item(FuncLoad, 6'($urandom_range(63 - active_n) + active_n), rand32(), rand32(),
                  rand32());
        query_all(1);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    idle_input();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
